// File: design/llzd_pkg.sv
// Shared types and codes for the least-loaded zone dispatcher.
package llzd_pkg;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_LOGIN = 2'd1;
  localparam logic [1:0] FUNC_DISC  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_ZERO      = 3'd1;
  localparam logic [2:0] STAT_DUP       = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND  = 3'd3;
  localparam logic [2:0] STAT_NOZONE    = 3'd4;
  localparam logic [2:0] STAT_FULL      = 3'd5;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] zone_id;
    logic [63:0] user_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] assigned_zone;
    logic [10:0] zone_users;
    logic [10:0] users_online;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_USCAN,
    S_ZSCAN,
    S_ZREAD,
    S_DCOMMIT,
    S_LCOMMIT,
    S_FINISH
  } state_t;

endpackage

// File: design/least_loaded_zone_dispatcher.sv
// Least-connections dispatcher: zone table, user table and scan sequencer.
// One transaction at a time; each scan reads one table entry per cycle through the single
// read port of the user or zone memory, so the user table scan sets the rate.
// Reset (synchronous) clears zone valid bits and the online count, then a clearing pass
// marks every user entry invalid; no request is taken during it.
module least_loaded_zone_dispatcher #(
  parameter int MAX_ZONES = 16,
  parameter int MAX_USERS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  llzd_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output llzd_pkg::rsp_t  rsp
);

  localparam int MAXN = (MAX_USERS > MAX_ZONES) ? MAX_USERS : MAX_ZONES;
  localparam int SW   = $clog2(MAXN + 1);
  localparam int CW   = $clog2(MAX_USERS + 1);
  localparam int ZAW  = $clog2(MAX_ZONES);
  localparam int UAW  = $clog2(MAX_USERS);

  typedef struct packed {
    logic [15:0]   ident;
    logic [CW-1:0] count;
  } zone_entry_t;

  typedef struct packed {
    logic           valid;
    logic [ZAW-1:0] slot;
    logic [63:0]    key;
  } user_entry_t;

  function automatic logic [10:0] to_out(input logic [CW-1:0] v);
    logic [CW+10:0] w;
    w = {11'b0, v};
    return w[10:0];
  endfunction

  llzd_pkg::state_t state, state_next;

  zone_entry_t zmem [MAX_ZONES];
  user_entry_t umem [MAX_USERS];
  zone_entry_t zq;
  user_entry_t uq;

  logic           zwe, uwe;
  logic [ZAW-1:0] zwaddr, zraddr;
  logic [UAW-1:0] uwaddr;
  zone_entry_t    zwdata;
  user_entry_t    uwdata;

  logic [MAX_ZONES-1:0] zone_valid;
  logic [CW-1:0]        online_total;

  logic [SW-1:0] scan_idx, scan_n, rd_slot;
  logic          rd_pend, issue, done;

  llzd_pkg::req_t req_q;
  llzd_pkg::rsp_t res;

  logic           zfound, zfree_found, best_found, umatch, ufree_found;
  logic [CW-1:0]  zfound_count, best_count;
  logic [ZAW-1:0] zfree_slot, best_slot, umatch_zone;
  logic [15:0]    best_ident;
  logic [UAW-1:0] umatch_slot, ufree_slot;

  logic accept, out_free, is_zero, zv;
  logic [CW-1:0] online_dec;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign scan_n   = (state == llzd_pkg::S_ZSCAN) ? SW'(MAX_ZONES) : SW'(MAX_USERS);
  assign issue    = scan_idx < scan_n;
  assign done     = !issue && !rd_pend;
  assign zv       = zone_valid[rd_slot[ZAW-1:0]];
  assign online_dec = (online_total != '0) ? online_total - 1'b1 : online_total;
  assign is_zero  = (req.func == llzd_pkg::FUNC_ADD && req.zone_id == 16'd0) ||
                    ((req.func == llzd_pkg::FUNC_LOGIN || req.func == llzd_pkg::FUNC_DISC) &&
                     req.user_id == 64'd0);

  always_ff @(posedge clk) begin
    if (zwe) zmem[zwaddr] <= zwdata;
    zq <= zmem[zraddr];
  end

  always_ff @(posedge clk) begin
    if (uwe) umem[uwaddr] <= uwdata;
    uq <= umem[scan_idx[UAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= llzd_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      llzd_pkg::S_CLEAR:
        if (scan_idx == SW'(MAX_USERS - 1)) state_next = llzd_pkg::S_IDLE;
      llzd_pkg::S_IDLE:
        if (accept) begin
          if (is_zero || req.func == llzd_pkg::FUNC_SPARE) state_next = llzd_pkg::S_FINISH;
          else if (req.func == llzd_pkg::FUNC_ADD) state_next = llzd_pkg::S_ZSCAN;
          else                                    state_next = llzd_pkg::S_USCAN;
        end
      llzd_pkg::S_USCAN:
        if (done) begin
          if (req_q.func == llzd_pkg::FUNC_LOGIN)
            state_next = umatch ? llzd_pkg::S_FINISH : llzd_pkg::S_ZSCAN;
          else
            state_next = umatch ? llzd_pkg::S_ZREAD : llzd_pkg::S_FINISH;
        end
      llzd_pkg::S_ZSCAN:
        if (done) begin
          if (req_q.func == llzd_pkg::FUNC_LOGIN && best_found && ufree_found)
            state_next = llzd_pkg::S_LCOMMIT;
          else
            state_next = llzd_pkg::S_FINISH;
        end
      llzd_pkg::S_ZREAD:   state_next = llzd_pkg::S_DCOMMIT;
      llzd_pkg::S_DCOMMIT: state_next = llzd_pkg::S_FINISH;
      llzd_pkg::S_LCOMMIT: state_next = llzd_pkg::S_FINISH;
      llzd_pkg::S_FINISH:
        if (out_free) state_next = llzd_pkg::S_IDLE;
      default: state_next = llzd_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    req_stall = (state != llzd_pkg::S_IDLE);
    zwe    = 1'b0;
    zwaddr = best_slot;
    zwdata = '{ident: best_ident, count: best_count + 1'b1};
    zraddr = (state == llzd_pkg::S_ZSCAN) ? scan_idx[ZAW-1:0] : umatch_zone;
    uwe    = 1'b0;
    uwaddr = scan_idx[UAW-1:0];
    uwdata = '{valid: 1'b0, slot: '0, key: '0};
    unique case (state)
      llzd_pkg::S_CLEAR: uwe = 1'b1;
      llzd_pkg::S_ZSCAN:
        if (done && req_q.func == llzd_pkg::FUNC_ADD && !zfound && zfree_found) begin
          zwe    = 1'b1;
          zwaddr = zfree_slot;
          zwdata = '{ident: req_q.zone_id, count: '0};
        end
      llzd_pkg::S_LCOMMIT: begin
        zwe    = 1'b1;
        uwe    = 1'b1;
        uwaddr = ufree_slot;
        uwdata = '{valid: 1'b1, slot: best_slot, key: req_q.user_id};
      end
      llzd_pkg::S_DCOMMIT: begin
        uwe    = 1'b1;
        uwaddr = umatch_slot;
        zwe    = (zq.count != '0);
        zwaddr = umatch_zone;
        zwdata = '{ident: zq.ident, count: zq.count - 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
      zone_valid   <= '0;
      online_total <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (state == llzd_pkg::S_FINISH && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        llzd_pkg::S_CLEAR:
          scan_idx <= (scan_idx == SW'(MAX_USERS - 1)) ? '0 : scan_idx + 1'b1;
        llzd_pkg::S_IDLE:
          if (accept) begin
            req_q       <= req;
            scan_idx    <= '0;
            rd_pend     <= 1'b0;
            zfound      <= 1'b0;
            zfree_found <= 1'b0;
            best_found  <= 1'b0;
            umatch      <= 1'b0;
            ufree_found <= 1'b0;
            res <= '{status: is_zero ? llzd_pkg::STAT_ZERO : llzd_pkg::STAT_OK,
                     assigned_zone: 16'd0, zone_users: 11'd0,
                     users_online: to_out(online_total)};
          end
        llzd_pkg::S_USCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
            rd_slot  <= scan_idx;
          end
          rd_pend <= issue;
          if (rd_pend) begin
            if (uq.valid && uq.key == req_q.user_id) begin
              umatch      <= 1'b1;
              umatch_slot <= rd_slot[UAW-1:0];
              umatch_zone <= uq.slot;
            end
            if (!uq.valid && !ufree_found) begin
              ufree_found <= 1'b1;
              ufree_slot  <= rd_slot[UAW-1:0];
            end
          end
          if (done) begin
            scan_idx <= '0;
            if (req_q.func == llzd_pkg::FUNC_LOGIN && umatch)
              res.status <= llzd_pkg::STAT_DUP;
            else if (req_q.func == llzd_pkg::FUNC_DISC && !umatch)
              res.status <= llzd_pkg::STAT_NOTFOUND;
          end
        end
        llzd_pkg::S_ZSCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
            rd_slot  <= scan_idx;
          end
          rd_pend <= issue;
          if (rd_pend) begin
            if (zv && zq.ident == req_q.zone_id) begin
              zfound       <= 1'b1;
              zfound_count <= zq.count;
            end
            if (!zv && !zfree_found) begin
              zfree_found <= 1'b1;
              zfree_slot  <= rd_slot[ZAW-1:0];
            end
            // ties on count go to the lower zone id
            if (zv && (!best_found || zq.count < best_count ||
                       (zq.count == best_count && zq.ident < best_ident))) begin
              best_found <= 1'b1;
              best_slot  <= rd_slot[ZAW-1:0];
              best_count <= zq.count;
              best_ident <= zq.ident;
            end
          end
          if (done) begin
            scan_idx <= '0;
            if (req_q.func == llzd_pkg::FUNC_ADD) begin
              if (zfound) begin
                res.status     <= llzd_pkg::STAT_DUP;
                res.zone_users <= to_out(zfound_count);
              end else if (!zfree_found) begin
                res.status <= llzd_pkg::STAT_FULL;
              end else begin
                zone_valid[zfree_slot] <= 1'b1;
              end
            end else if (!best_found) begin
              res.status <= llzd_pkg::STAT_NOZONE;
            end else if (!ufree_found) begin
              res.status <= llzd_pkg::STAT_FULL;
            end
          end
        end
        llzd_pkg::S_LCOMMIT: begin
          online_total <= online_total + 1'b1;
          res <= '{status: llzd_pkg::STAT_OK, assigned_zone: best_ident,
                   zone_users: to_out(best_count + 1'b1),
                   users_online: to_out(online_total + 1'b1)};
        end
        llzd_pkg::S_DCOMMIT: begin
          online_total <= online_dec;
          res <= '{status: (zq.count == '0) ? llzd_pkg::STAT_UNDERFLOW : llzd_pkg::STAT_OK,
                   assigned_zone: zq.ident,
                   zone_users: (zq.count == '0) ? 11'd0 : to_out(zq.count - 1'b1),
                   users_online: to_out(online_dec)};
        end
        default: ;
      endcase
    end
  end

  a_online_bound: assert property (@(posedge clk) disable iff (rst)
    online_total <= CW'(MAX_USERS))
    else $error("online count above table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request taken while previous one still in flight");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == llzd_pkg::S_FINISH)
    else $error("response raised outside finish state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_idx <= SW'(MAXN))
    else $error("scan index out of range");

endmodule
